/* hw/rtl/pqd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the min-cost priority queue with decrease-key.
// No dependencies; used by pqd_cell, pqd_chain and min_priority_queue_decrease_key.
package pqd_pkg;

	localparam int DEF_QUEUE_DEPTH = 64;
	localparam int DEF_NODE_BITS   = 16;

	localparam int OP_W      = 3;
	localparam int IN_NODE_W = 16;
	localparam int COST_W    = 32;
	localparam int STAT_W    = 2;
	localparam int CNT_OUT_W = 7;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 64;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 3'd0,
		OP_POP      = 3'd1,
		OP_CHANGE   = 3'd2,
		OP_REMOVE   = 3'd3,
		OP_CONTAINS = 3'd4
	} pqd_op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} pqd_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE
	} pqd_state_t;

	// Update command broadcast along the chain of cells.
	typedef struct packed {
		logic ins;
		logic del;
		logic del_head;
	} pqd_cmd_t;

endpackage

/* hw/rtl/min_priority_queue_decrease_key.sv */
`timescale 1ns / 1ps
// Top level of the min-cost priority queue with decrease-key: sequencer,
// entry count and result register around pqd_chain. Uses pqd_pkg and pqd_chain.
//
//   port group   dir  contents (lowest bits first)
//   s_*          in   tuser: opcode; tdata: node_id, cost
//   m_*          out  tdata: found, status, head_valid, head_node, head_cost,
//                     entry_count
//
// An item first has the compares registered in every cell, then shifts the
// chain. Change priority adds a fresh compare and an insertion pass after
// its removal pass. The final shift of an item is held back while the
// result register is full and not being taken. Reset clears the valid bit of
// every cell and the entry count; no clearing pass is needed.
module min_priority_queue_decrease_key #(
	parameter int QUEUE_DEPTH = pqd_pkg::DEF_QUEUE_DEPTH,
	parameter int NODE_BITS   = pqd_pkg::DEF_NODE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pqd_pkg::S_TDATA_W-1:0] s_tdata,  // node_id, cost
	input  logic [pqd_pkg::OP_W-1:0]      s_tuser,  // opcode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pqd_pkg::M_TDATA_W-1:0] m_tdata   // found, status, head_valid,
	                                                // head_node, head_cost, entry_count
);
	import pqd_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	pqd_state_t             state_q, state_d;
	logic [OP_W-1:0]        op_q;
	logic [NODE_BITS-1:0]   node_q;
	logic [COST_W-1:0]      cost_q;
	logic                   phase_q, phase_d;
	logic [CNT_W-1:0]       count_q, count_d;
	logic                   m_tvalid_q;
	logic [M_TDATA_W-1:0]   m_tdata_q;

	pqd_cmd_t               cmd, cmd_pre;
	logic                   ld_out;
	logic                   out_free;
	logic                   mid;
	logic                   res_found;
	pqd_status_t            res_status;
	logic                   accept;

	logic [NODE_BITS+IN_NODE_W-1:0] in_node_ext;
	logic [NODE_BITS-1:0]           in_node;
	logic [NODE_BITS-1:0]           key_node;
	logic [COST_W-1:0]              key_cost;

	logic                   found_w;
	logic                   hd_valid;
	logic [COST_W-1:0]      hd_cost;
	logic [NODE_BITS-1:0]   hd_node;
	logic [NODE_BITS+IN_NODE_W-1:0] hd_node_ext;
	logic [CNT_W+CNT_OUT_W-1:0]     cnt_ext;

	assign accept      = s_tvalid && s_tready;
	assign s_tready    = (state_q == S_IDLE);
	assign out_free    = !m_tvalid_q || m_tready;
	assign in_node_ext = {{NODE_BITS{1'b0}}, s_tdata[IN_NODE_W-1:0]};
	assign in_node     = in_node_ext[NODE_BITS-1:0];
	assign key_node    = (state_q == S_IDLE) ? in_node : node_q;
	assign key_cost    = (state_q == S_IDLE) ? s_tdata[IN_NODE_W +: COST_W] : cost_q;

	pqd_chain #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.NODE_BITS   (NODE_BITS)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.key_node   (key_node),
		.key_cost   (key_cost),
		.found      (found_w),
		.head_valid (hd_valid),
		.head_cost  (hd_cost),
		.head_node  (hd_node)
	);

	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		cmd_pre    = '0;
		cmd        = '0;
		ld_out     = 1'b0;
		res_found  = 1'b0;
		res_status = STAT_OK;
		mid        = 1'b0;
		count_d    = count_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_UPDATE;
					phase_d = 1'b0;
				end
			end
			S_SCAN: begin
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				case (op_q)
					OP_INSERT: begin
						if (count_q == FULL_CNT) begin
							res_status = STAT_FULL;
						end else begin
							cmd_pre.ins = 1'b1;
						end
					end
					OP_POP: begin
						if (count_q == '0) begin
							res_status = STAT_EMPTY;
						end else begin
							cmd_pre.del      = 1'b1;
							cmd_pre.del_head = 1'b1;
						end
					end
					OP_CHANGE: begin
						if (phase_q) begin
							cmd_pre.ins = 1'b1;
							res_found   = 1'b1;
						end else if (found_w) begin
							cmd_pre.del = 1'b1;
							mid         = 1'b1;
						end
					end
					OP_REMOVE: begin
						cmd_pre.del = found_w;
						res_found   = found_w;
					end
					OP_CONTAINS: begin
						res_found = found_w;
					end
					default: begin
					end
				endcase
				if (mid) begin
					cmd     = cmd_pre;
					state_d = S_SCAN;
					phase_d = 1'b1;
				end else if (out_free) begin
					cmd     = cmd_pre;
					ld_out  = 1'b1;
					state_d = S_IDLE;
				end
				if (cmd.ins) begin
					count_d = count_q + CNT_W'(1);
				end else if (cmd.del) begin
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign hd_node_ext = {{IN_NODE_W{1'b0}}, hd_node};
	assign cnt_ext     = {{CNT_OUT_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= 1'b0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			count_q <= count_d;
			if (ld_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= s_tuser;
			node_q <= in_node;
			cost_q <= s_tdata[IN_NODE_W +: COST_W];
		end
		if (ld_out) begin
			m_tdata_q <= {
				{(M_TDATA_W - 59){1'b0}},
				cnt_ext[CNT_OUT_W-1:0],
				hd_valid ? hd_cost : {COST_W{1'b0}},
				hd_valid ? hd_node_ext[IN_NODE_W-1:0] : {IN_NODE_W{1'b0}},
				hd_valid,
				res_status,
				res_found
			};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count exceeds the queue depth");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins && cmd.del))
		else $error("insert and removal shift in the same cycle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ld_out && m_tvalid_q) |-> m_tready)
		else $error("result register overwritten before it was taken");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_UPDATE))
		else $error("accepted item did not start an update");

	a_chain_shift_only_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ins || cmd.del) |-> (state_q == S_UPDATE))
		else $error("chain shifted outside an update cycle");

endmodule

/* hw/rtl/pqd_cell.sv */
`timescale 1ns / 1ps
// One slot of the sorted queue: holds an entry, compares it with the key and takes
// over its left neighbour's entry or the key on insert, its right neighbour's on removal. Uses pqd_pkg.
module pqd_cell #(
	parameter int NODE_BITS = pqd_pkg::DEF_NODE_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pqd_pkg::pqd_cmd_t         cmd,
	input  logic [NODE_BITS-1:0]      key_node,
	input  logic [pqd_pkg::COST_W-1:0] key_cost,
	input  logic                      ge,
	input  logic                      l_valid,
	input  logic [pqd_pkg::COST_W-1:0] l_cost,
	input  logic [NODE_BITS-1:0]      l_node,
	input  logic                      l_take,
	input  logic                      r_valid,
	input  logic [pqd_pkg::COST_W-1:0] r_cost,
	input  logic [NODE_BITS-1:0]      r_node,
	output logic                      valid,
	output logic [pqd_pkg::COST_W-1:0] cost,
	output logic [NODE_BITS-1:0]      node,
	output logic                      take,
	output logic                      match,
	output logic                      nxt_valid,
	output logic [pqd_pkg::COST_W-1:0] nxt_cost,
	output logic [NODE_BITS-1:0]      nxt_node
);
	import pqd_pkg::*;

	logic                 valid_q;
	logic [COST_W-1:0]    cost_q;
	logic [NODE_BITS-1:0] node_q;
	logic                 take_s1;
	logic                 match_s1;

	always_comb begin
		nxt_valid = valid_q;
		nxt_cost  = cost_q;
		nxt_node  = node_q;
		if (cmd.del && ge) begin
			nxt_valid = r_valid;
			nxt_cost  = r_cost;
			nxt_node  = r_node;
		end else if (cmd.ins && take_s1) begin
			if (l_take) begin
				nxt_valid = l_valid;
				nxt_cost  = l_cost;
				nxt_node  = l_node;
			end else begin
				nxt_valid = 1'b1;
				nxt_cost  = key_cost;
				nxt_node  = key_node;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			take_s1  <= 1'b0;
			match_s1 <= 1'b0;
		end else begin
			valid_q  <= nxt_valid;
			take_s1  <= !valid_q || (cost_q > key_cost);
			match_s1 <= valid_q && (node_q == key_node);
		end
	end

	always_ff @(posedge clk) begin
		cost_q <= nxt_cost;
		node_q <= nxt_node;
	end

	assign valid = valid_q;
	assign cost  = cost_q;
	assign node  = node_q;
	assign take  = take_s1;
	assign match = match_s1;

endmodule

/* hw/rtl/pqd_chain.sv */
`timescale 1ns / 1ps
// Row of pqd_cell slots kept in ascending cost order, with the first-match
// mask that selects the slots shifting left on removal. Uses pqd_pkg and pqd_cell.
module pqd_chain #(
	parameter int QUEUE_DEPTH = pqd_pkg::DEF_QUEUE_DEPTH,
	parameter int NODE_BITS   = pqd_pkg::DEF_NODE_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pqd_pkg::pqd_cmd_t          cmd,
	input  logic [NODE_BITS-1:0]       key_node,
	input  logic [pqd_pkg::COST_W-1:0] key_cost,
	output logic                       found,
	output logic                       head_valid,
	output logic [pqd_pkg::COST_W-1:0] head_cost,
	output logic [NODE_BITS-1:0]       head_node
);
	import pqd_pkg::*;

	logic                 valid_v     [QUEUE_DEPTH];
	logic [COST_W-1:0]    cost_v      [QUEUE_DEPTH];
	logic [NODE_BITS-1:0] node_v      [QUEUE_DEPTH];
	logic                 take_v      [QUEUE_DEPTH];
	logic                 nxt_valid_v [QUEUE_DEPTH];
	logic [COST_W-1:0]    nxt_cost_v  [QUEUE_DEPTH];
	logic [NODE_BITS-1:0] nxt_node_v  [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] match_vec;
	logic [QUEUE_DEPTH-1:0] ge_vec;

	// On pop every slot moves one place left; otherwise every slot from the first matching one upwards does.
	assign ge_vec = cmd.del_head ? {QUEUE_DEPTH{1'b1}}
	                             : (match_vec | (~match_vec + QUEUE_DEPTH'(1)));
	assign found  = |match_vec;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                 l_valid;
		logic [COST_W-1:0]    l_cost;
		logic [NODE_BITS-1:0] l_node;
		logic                 l_take;
		logic                 r_valid;
		logic [COST_W-1:0]    r_cost;
		logic [NODE_BITS-1:0] r_node;

		if (i == 0) begin : g_first
			assign l_valid = 1'b0;
			assign l_cost  = '0;
			assign l_node  = '0;
			assign l_take  = 1'b0;
		end else begin : g_mid_l
			assign l_valid = valid_v[i-1];
			assign l_cost  = cost_v[i-1];
			assign l_node  = node_v[i-1];
			assign l_take  = take_v[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign r_valid = 1'b0;
			assign r_cost  = '0;
			assign r_node  = '0;
		end else begin : g_mid_r
			assign r_valid = valid_v[i+1];
			assign r_cost  = cost_v[i+1];
			assign r_node  = node_v[i+1];
		end

		pqd_cell #(
			.NODE_BITS (NODE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.key_node  (key_node),
			.key_cost  (key_cost),
			.ge        (ge_vec[i]),
			.l_valid   (l_valid),
			.l_cost    (l_cost),
			.l_node    (l_node),
			.l_take    (l_take),
			.r_valid   (r_valid),
			.r_cost    (r_cost),
			.r_node    (r_node),
			.valid     (valid_v[i]),
			.cost      (cost_v[i]),
			.node      (node_v[i]),
			.take      (take_v[i]),
			.match     (match_vec[i]),
			.nxt_valid (nxt_valid_v[i]),
			.nxt_cost  (nxt_cost_v[i]),
			.nxt_node  (nxt_node_v[i])
		);
	end

	assign head_valid = nxt_valid_v[0];
	assign head_cost  = nxt_cost_v[0];
	assign head_node  = nxt_node_v[0];

endmodule

/* tb/min_priority_queue_decrease_key_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for min_priority_queue_decrease_key: a directed opening, then random
// fill, drain and mixed phases, with every result checked against a sorted shadow queue.
// Depends on pqd_pkg and the RTL of min_priority_queue_decrease_key.
module min_priority_queue_decrease_key_tb;
	import pqd_pkg::*;

	localparam int DEPTH            = DEF_QUEUE_DEPTH;
	localparam int ITEM_TARGET      = 1400;
	localparam int SETTLE_CYCLES    = 16;
	localparam int CHOKE_AFTER      = 300;
	localparam int CHOKE_CYCLES     = 400;
	localparam int MAX_REPORTS      = 40;
	localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_UNUSED_MID   = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
	localparam logic [COST_W-1:0] COST_MAX      = 32'hFFFF_FFFF;
	localparam logic [COST_W-1:0] COST_ONE      = 32'h0001_0000;
	localparam logic [COST_W-1:0] COST_THREE    = 32'h0003_0000;

	typedef struct {
		logic [OP_W-1:0]      op;
		logic [IN_NODE_W-1:0] node;
		logic [COST_W-1:0]    cost;
		bit                   rush;
	} pq_item_t;

	typedef struct packed {
		logic                 found;
		logic [STAT_W-1:0]    status;
		logic                 head_valid;
		logic [IN_NODE_W-1:0] head_node;
		logic [COST_W-1:0]    head_cost;
		logic [CNT_OUT_W-1:0] entry_count;
	} pq_result_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;  // node_id, cost
	logic [OP_W-1:0]      s_tuser  = '0;  // opcode
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // found, status, head_valid, head_node, head_cost,
	                                      // entry_count

	pq_item_t   op_backlog[$];
	pq_result_t awaited_heads[$];
	pq_item_t   cur_item;
	bit         gen_rush     = 1'b0;
	bit         rushing      = 1'b0;
	int         generated    = 0;
	int         taken_items  = 0;
	int         results_seen = 0;
	int         mismatches   = 0;
	int         send_idle    = 0;
	int         recv_stall   = 0;
	int         choke_left   = 0;
	bit         choke_done   = 1'b0;

	logic [COST_W-1:0]    shadow_cost[DEPTH];
	logic [IN_NODE_W-1:0] shadow_node[DEPTH];
	int                   shadow_len = 0;

	min_priority_queue_decrease_key u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	function automatic logic [IN_NODE_W-1:0] rand_node();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return 16'($urandom_range(0, 11));
		if (r < 88)
			return 16'hFFF0 | 16'($urandom_range(0, 15));
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic logic [COST_W-1:0] rand_cost();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return {16'($urandom_range(0, 7)), 16'h0000};
		if (r < 45)
			return $urandom_range(0, 1) ? COST_MAX : '0;
		return $urandom();
	endfunction

	task automatic add_item(input logic [OP_W-1:0] op, input logic [IN_NODE_W-1:0] node,
			input logic [COST_W-1:0] cost);
		pq_item_t it;
		it.op   = op;
		it.node = node;
		it.cost = cost;
		it.rush = gen_rush;
		op_backlog = {op_backlog, it};
		generated++;
	endtask

	function automatic int shadow_find(input logic [IN_NODE_W-1:0] node);
		int i;
		i = 0;
		while (i < shadow_len && shadow_node[i] != node)
			i++;
		return i;
	endfunction

	// A new entry goes behind every held entry of equal or lower cost.
	task automatic shadow_put(input logic [IN_NODE_W-1:0] node, input logic [COST_W-1:0] cost);
		int p;
		int i;
		p = 0;
		while (p < shadow_len && shadow_cost[p] <= cost)
			p++;
		for (i = shadow_len; i > p; i--) begin
			shadow_cost[i] = shadow_cost[i-1];
			shadow_node[i] = shadow_node[i-1];
		end
		shadow_cost[p] = cost;
		shadow_node[p] = node;
		shadow_len++;
	endtask

	task automatic shadow_take(input int p);
		int i;
		for (i = p; i + 1 < shadow_len; i++) begin
			shadow_cost[i] = shadow_cost[i+1];
			shadow_node[i] = shadow_node[i+1];
		end
		shadow_len--;
	endtask

	task automatic queue_model_apply(input pq_item_t it, output pq_result_t r);
		int idx;
		r = '0;
		r.status = STAT_OK;
		case (it.op)
			OP_INSERT: begin
				if (shadow_len >= DEPTH)
					r.status = STAT_FULL;
				else
					shadow_put(it.node, it.cost);
			end
			OP_POP: begin
				if (shadow_len == 0)
					r.status = STAT_EMPTY;
				else
					shadow_take(0);
			end
			OP_CHANGE: begin
				idx = shadow_find(it.node);
				if (idx < shadow_len) begin
					r.found = 1'b1;
					shadow_take(idx);
					shadow_put(it.node, it.cost);
				end
			end
			OP_REMOVE: begin
				idx = shadow_find(it.node);
				if (idx < shadow_len) begin
					r.found = 1'b1;
					shadow_take(idx);
				end
			end
			OP_CONTAINS: r.found = (shadow_find(it.node) < shadow_len);
			default: ;
		endcase
		r.head_valid  = (shadow_len != 0);
		r.head_node   = (shadow_len != 0) ? shadow_node[0] : '0;
		r.head_cost   = (shadow_len != 0) ? shadow_cost[0] : '0;
		r.entry_count = shadow_len[CNT_OUT_W-1:0];
	endtask

	task automatic flag_mismatch(input string what, input logic [COST_W-1:0] got,
			input logic [COST_W-1:0] want);
		if (mismatches < MAX_REPORTS)
			$display("mismatch on result %0d, %s: got %0h, expected %0h",
				results_seen, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pq_result_t r;
		pq_item_t   nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			rushing  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				queue_model_apply(cur_item, r);
				awaited_heads = {awaited_heads, r};
				taken_items <= taken_items + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (send_idle != 0 && choke_left == 0) begin
					send_idle--;
					s_tvalid <= 1'b0;
				end else if (op_backlog.size() != 0) begin
					nxt      = op_backlog.pop_front();
					cur_item = nxt;
					s_tdata  <= {nxt.cost, nxt.node};
					s_tuser  <= nxt.op;
					s_tvalid <= 1'b1;
					rushing  <= nxt.rush;
					send_idle = nxt.rush ? 0 : pick_idle();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// One long hold-off of the receiver, so that the queue backs up into its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			choke_left <= 0;
			choke_done <= 1'b0;
		end else if (choke_left != 0) begin
			choke_left <= choke_left - 1;
		end else if (!choke_done && taken_items >= CHOKE_AFTER) begin
			choke_left <= CHOKE_CYCLES;
			choke_done <= 1'b1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		pq_result_t got;
		pq_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.found       = m_tdata[0];
				got.status      = m_tdata[2:1];
				got.head_valid  = m_tdata[3];
				got.head_node   = m_tdata[19:4];
				got.head_cost   = m_tdata[51:20];
				got.entry_count = m_tdata[58:52];
				if (awaited_heads.size() == 0) begin
					flag_mismatch("result with none expected", '0, '0);
				end else begin
					want = awaited_heads.pop_front();
					if (got.found !== want.found)
						flag_mismatch("found", COST_W'(got.found), COST_W'(want.found));
					if (got.status !== want.status)
						flag_mismatch("status", COST_W'(got.status), COST_W'(want.status));
					if (got.head_valid !== want.head_valid)
						flag_mismatch("head_valid", COST_W'(got.head_valid),
							COST_W'(want.head_valid));
					if (got.head_node !== want.head_node)
						flag_mismatch("head_node", COST_W'(got.head_node),
							COST_W'(want.head_node));
					if (got.head_cost !== want.head_cost)
						flag_mismatch("head_cost", got.head_cost, want.head_cost);
					if (got.entry_count !== want.entry_count)
						flag_mismatch("entry_count", COST_W'(got.entry_count),
							COST_W'(want.entry_count));
				end
				results_seen++;
			end
			if (choke_left != 0) begin
				m_tready <= 1'b0;
			end else if (recv_stall != 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				recv_stall = rushing ? 0 : pick_idle();
			end
		end
	end

	initial begin
		int phase;
		int n;
		int k;
		int r;

		add_item(OP_CONTAINS, 16'd5, '0);
		add_item(OP_POP, 16'd0, '0);
		add_item(OP_CHANGE, 16'd5, COST_ONE);
		add_item(OP_REMOVE, 16'd5, '0);
		add_item(OP_INSERT, 16'd5, COST_THREE);
		add_item(OP_INSERT, 16'hFFFF, COST_MAX);
		add_item(OP_INSERT, 16'd0, '0);
		add_item(OP_INSERT, 16'd7, COST_THREE);
		add_item(OP_INSERT, 16'd5, COST_ONE);
		add_item(OP_CONTAINS, 16'd5, COST_MAX);
		add_item(OP_CONTAINS, 16'd9, '0);
		add_item(OP_CHANGE, 16'd5, COST_THREE);
		add_item(OP_CHANGE, 16'd9, COST_ONE);
		add_item(OP_REMOVE, 16'd5, '0);
		add_item(OP_REMOVE, 16'd9, '0);
		add_item(OP_UNUSED_FIRST, 16'hFFFF, COST_MAX);
		add_item(OP_UNUSED_MID, 16'd0, '0);
		add_item(OP_UNUSED_LAST, 16'd5, COST_ONE);
		repeat (6) add_item(OP_POP, 16'd0, '0);

		phase = 0;
		while (generated < ITEM_TARGET) begin
			gen_rush = ($urandom_range(0, 3) == 0);
			if (phase % 3 == 2) begin
				n = $urandom_range(DEPTH + 2, DEPTH + 8);
				for (k = 0; k < n; k++) begin
					add_item(OP_INSERT, rand_node(), rand_cost());
					if ($urandom_range(0, 4) == 0)
						add_item($urandom_range(0, 1) ? OP_CHANGE : OP_CONTAINS,
							rand_node(), rand_cost());
				end
				n = $urandom_range(DEPTH, DEPTH + 6);
				for (k = 0; k < n; k++) begin
					add_item(OP_POP, rand_node(), rand_cost());
					if ($urandom_range(0, 6) == 0)
						add_item(OP_REMOVE, rand_node(), rand_cost());
				end
			end else begin
				for (k = 0; k < 80; k++) begin
					r = $urandom_range(0, 99);
					if (r < 34)
						add_item(OP_INSERT, rand_node(), rand_cost());
					else if (r < 50)
						add_item(OP_POP, rand_node(), rand_cost());
					else if (r < 68)
						add_item(OP_CHANGE, rand_node(), rand_cost());
					else if (r < 84)
						add_item(OP_REMOVE, rand_node(), rand_cost());
					else if (r < 96)
						add_item(OP_CONTAINS, rand_node(), rand_cost());
					else
						add_item(OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
							rand_node(), rand_cost());
				end
			end
			phase++;
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (op_backlog.size() != 0 || s_tvalid || awaited_heads.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && awaited_heads.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* min_priority_queue_decrease_key.f */
hw/rtl/pqd_pkg.sv
hw/rtl/pqd_cell.sv
hw/rtl/pqd_chain.sv
hw/rtl/min_priority_queue_decrease_key.sv
tb/min_priority_queue_decrease_key_tb.sv
